FILE: hdl/bcs_pkg.sv
// Shared types and constants of the bilinear crop-and-scale block.
package bcs_pkg;

   // Width of the signed sample address arithmetic.
   localparam int SAMP_W = 48;
   localparam int CSR_W = 24;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      CSR_CHANNEL_COUNT = 3'd0,
      CSR_SOURCE_WIDTH  = 3'd1,
      CSR_SOURCE_HEIGHT = 3'd2,
      CSR_CROP_LEFT     = 3'd3,
      CSR_CROP_TOP      = 3'd4,
      CSR_STEP_X        = 3'd5,
      CSR_STEP_Y        = 3'd6,
      CSR_DEST_WIDTH    = 3'd7
   } csr_index_type;

   // Configuration as seen by the datapath; channels is already clamped.
   typedef struct packed {
      logic [2:0]  channels;
      logic [10:0] source_width;
      logic [10:0] source_height;
      logic [9:0]  crop_left;
      logic [9:0]  crop_top;
      logic [23:0] step_x;
      logic [23:0] step_y;
      logic [10:0] dest_width;
   } cfg_type;

endpackage

FILE: hdl/bcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bcs_map.sv
// Four-stage mapping pipeline: box offset, step products, source position and weights.
module bcs_map #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bcs_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_opcode,
   input  logic [19:0]                 in_load_address,
   input  logic [7:0]                  in_load_value,
   input  logic [9:0]                  in_dest_col,
   input  logic [9:0]                  in_dest_row,
   input  logic [9:0]                  in_box_left,
   input  logic [9:0]                  in_box_top,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        out_load,
   output logic [19:0]                 out_load_address,
   output logic [7:0]                  out_load_value,
   output logic [bcs_pkg::SAMP_W-1:0]  out_sx,
   output logic [bcs_pkg::SAMP_W-1:0]  out_syw,
   output logic                        out_sx_last,
   output logic                        out_sy_last,
   output logic [2*FRACTION_BITS:0]    out_wa,
   output logic [2*FRACTION_BITS:0]    out_wb,
   output logic [2*FRACTION_BITS:0]    out_wc,
   output logic [2*FRACTION_BITS:0]    out_wd,
   output logic [21:0]                 out_row_addr
);

   localparam int FB = FRACTION_BITS;
   localparam int PX_W = 34;
   localparam int IW = PX_W - FB + 1;
   localparam int WW = 2 * FB + 1;
   localparam int SW = bcs_pkg::SAMP_W;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   // Stage 1: offsets inside the box.
   logic s1_v_ff, s1_op_ff;
   logic [19:0] s1_la_ff;
   logic [7:0]  s1_lv_ff;
   logic [9:0]  s1_col_ff, s1_row_ff, s1_ox_ff, s1_oy_ff;
   // Stage 2: step products and destination row product.
   logic s2_v_ff, s2_op_ff;
   logic [19:0] s2_la_ff;
   logic [7:0]  s2_lv_ff;
   logic [9:0]  s2_col_ff;
   logic [PX_W-1:0] s2_px_ff, s2_py_ff;
   logic [20:0] s2_rowprod_ff;
   // Stage 3: source position and fractions.
   logic s3_v_ff, s3_op_ff;
   logic [19:0] s3_la_ff;
   logic [7:0]  s3_lv_ff;
   logic [IW-1:0] s3_sx_ff, s3_sy_ff;
   logic [FB-1:0] s3_fx_ff, s3_fy_ff;
   logic [21:0] s3_rowsum_ff;
   // Stage 4: row offset, edge flags and blend weights.
   logic s4_v_ff, s4_op_ff;
   logic [19:0] s4_la_ff;
   logic [7:0]  s4_lv_ff;
   logic [SW-1:0] s4_sx_ff, s4_syw_ff;
   logic s4_sxl_ff, s4_syl_ff;
   logic [WW-1:0] s4_wa_ff, s4_wb_ff, s4_wc_ff, s4_wd_ff;
   logic [21:0] s4_row_ff;

   logic s1_free, s2_free, s3_free, s4_free;
   logic [PX_W-1:0] px_in, py_in;
   logic [20:0] rowprod_in;
   logic [IW-1:0] sx_in, sy_in;
   logic [21:0] rowsum_in;
   logic [IW+10:0] syw_full;
   logic [24:0] row_full;
   logic [FB:0] omfx, omfy, fx_e, fy_e;
   logic [2*FB+1:0] pa, pb, pc, pd;

   assign s4_free = !s4_v_ff || out_ready;
   assign s3_free = !s3_v_ff || s4_free;
   assign s2_free = !s2_v_ff || s3_free;
   assign s1_free = !s1_v_ff || s2_free;
   assign in_ready = s1_free;

   assign px_in = s1_ox_ff * cfg.step_x;
   assign py_in = s1_oy_ff * cfg.step_y;
   assign rowprod_in = s1_row_ff * cfg.dest_width;

   assign sx_in = IW'(s2_px_ff[PX_W-1:FB]) + IW'(cfg.crop_left);
   assign sy_in = IW'(s2_py_ff[PX_W-1:FB]) + IW'(cfg.crop_top);
   assign rowsum_in = 22'(s2_rowprod_ff) + 22'(s2_col_ff);

   assign syw_full = s3_sy_ff * cfg.source_width;
   assign row_full = s3_rowsum_ff * cfg.channels;
   assign fx_e = {1'b0, s3_fx_ff};
   assign fy_e = {1'b0, s3_fy_ff};
   assign omfx = ONE - fx_e;
   assign omfy = ONE - fy_e;
   assign pa = omfx * omfy;
   assign pb = fx_e * omfy;
   assign pc = omfx * fy_e;
   assign pd = fx_e * fy_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= in_valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_free) begin
            s4_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_op_ff  <= in_opcode;
         s1_la_ff  <= in_load_address;
         s1_lv_ff  <= in_load_value;
         s1_col_ff <= in_dest_col;
         s1_row_ff <= in_dest_row;
         s1_ox_ff  <= in_dest_col - in_box_left;
         s1_oy_ff  <= in_dest_row - in_box_top;
      end
      if (s2_free) begin
         s2_op_ff      <= s1_op_ff;
         s2_la_ff      <= s1_la_ff;
         s2_lv_ff      <= s1_lv_ff;
         s2_col_ff     <= s1_col_ff;
         s2_px_ff      <= px_in;
         s2_py_ff      <= py_in;
         s2_rowprod_ff <= rowprod_in;
      end
      if (s3_free) begin
         s3_op_ff     <= s2_op_ff;
         s3_la_ff     <= s2_la_ff;
         s3_lv_ff     <= s2_lv_ff;
         s3_sx_ff     <= sx_in;
         s3_sy_ff     <= sy_in;
         s3_fx_ff     <= s2_px_ff[FB-1:0];
         s3_fy_ff     <= s2_py_ff[FB-1:0];
         s3_rowsum_ff <= rowsum_in;
      end
      if (s4_free) begin
         s4_op_ff  <= s3_op_ff;
         s4_la_ff  <= s3_la_ff;
         s4_lv_ff  <= s3_lv_ff;
         s4_sx_ff  <= SW'(s3_sx_ff);
         s4_syw_ff <= SW'(syw_full);
         s4_sxl_ff <= (SW'(s3_sx_ff) == SW'(cfg.source_width) - SW'(1));
         s4_syl_ff <= (SW'(s3_sy_ff) == SW'(cfg.source_height) - SW'(1));
         s4_wa_ff  <= pa[WW-1:0];
         s4_wb_ff  <= pb[WW-1:0];
         s4_wc_ff  <= pc[WW-1:0];
         s4_wd_ff  <= pd[WW-1:0];
         s4_row_ff <= row_full[21:0];
      end
   end

   assign out_valid        = s4_v_ff;
   assign out_load         = (s4_op_ff == bcs_pkg::OP_LOAD);
   assign out_load_address = s4_la_ff;
   assign out_load_value   = s4_lv_ff;
   assign out_sx           = s4_sx_ff;
   assign out_syw          = s4_syw_ff;
   assign out_sx_last      = s4_sxl_ff;
   assign out_sy_last      = s4_syl_ff;
   assign out_wa           = s4_wa_ff;
   assign out_wb           = s4_wb_ff;
   assign out_wc           = s4_wc_ff;
   assign out_wd           = s4_wd_ff;
   assign out_row_addr     = s4_row_ff;

endmodule

FILE: hdl/bcs_lane.sv
// Channel sequencer, source store copies, tap read and blend pipeline.
module bcs_lane #(
   parameter int SOURCE_BYTES = 1048576,
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bcs_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_load,
   input  logic [19:0]                 in_load_address,
   input  logic [7:0]                  in_load_value,
   input  logic [bcs_pkg::SAMP_W-1:0]  in_sx,
   input  logic [bcs_pkg::SAMP_W-1:0]  in_syw,
   input  logic                        in_sx_last,
   input  logic                        in_sy_last,
   input  logic [2*FRACTION_BITS:0]    in_wa,
   input  logic [2*FRACTION_BITS:0]    in_wb,
   input  logic [2*FRACTION_BITS:0]    in_wc,
   input  logic [2*FRACTION_BITS:0]    in_wd,
   input  logic [21:0]                 in_row_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [21:0]                 rsp_dest_address,
   output logic [7:0]                  rsp_pixel_value,
   output logic [1:0]                  rsp_channel_index,
   output logic                        rsp_range_error,
   output logic                        rsp_last
);

   localparam int FB = FRACTION_BITS;
   localparam int WW = 2 * FB + 1;
   localparam int PW = WW + 8;
   localparam int SUM_W = PW + 2;
   localparam int SW = bcs_pkg::SAMP_W;
   localparam int AW = $clog2(SOURCE_BYTES);
   localparam logic [SW-1:0] STORE_END = SW'(SOURCE_BYTES);

   // Tap order: 0 = top left, 1 = top right, 2 = bottom left, 3 = bottom right.
   logic e_v_ff, e_load_ff;
   logic [19:0] e_la_ff;
   logic [7:0]  e_lv_ff;
   logic [SW-1:0] e_addr_ff [4];
   logic [WW-1:0] e_w_ff [4];
   logic [21:0] e_row_ff;
   logic [1:0]  e_c_ff, e_lastc_ff;

   logic r_v_ff, r_err_ff, r_last_ff;
   logic [21:0] r_addr_ff;
   logic [1:0]  r_c_ff;
   logic [WW-1:0] r_w_ff [4];

   logic m_v_ff, m_err_ff, m_last_ff;
   logic [21:0] m_addr_ff;
   logic [1:0]  m_c_ff;
   logic [PW-1:0] m_p_ff [4];

   logic o_v_ff, o_err_ff, o_last_ff;
   logic [21:0] o_addr_ff;
   logic [1:0]  o_c_ff;
   logic [7:0]  o_val_ff;

   logic adv, e_done, take_e, issue, err_now, load_ok, wr_en;
   logic [SW-1:0] chs, wch, base, i1, i2, i3, i4;
   logic [SW-1:0] tap_addr [4];
   logic [3:0]  tap_out;
   logic [7:0]  rd_data [4];
   logic [SUM_W-1:0] sum;
   logic [SW-1:0] la_ext;

   assign adv    = !o_v_ff || rsp_ready;
   assign e_done = e_load_ff || (e_c_ff == e_lastc_ff);
   assign take_e = !e_v_ff || (adv && e_done);
   assign in_ready = take_e;
   assign issue  = e_v_ff && !e_load_ff;

   // Sample addresses of channel zero.
   assign chs  = SW'(cfg.channels);
   assign wch  = SW'(cfg.source_width) * chs;
   assign base = in_syw + in_sx;
   assign i1   = SW'(base * cfg.channels);
   assign i2   = in_sy_last ? i1 - wch : i1 + wch;
   assign i3   = in_sx_last ? i1 - chs : i1 + chs;
   assign i4   = in_sx_last ? i2 - chs : i2 + chs;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tap_addr[k] = e_addr_ff[k] + SW'(e_c_ff);
         tap_out[k]  = tap_addr[k][SW-1] || (tap_addr[k] >= STORE_END);
      end
   end
   assign err_now = |tap_out;

   assign la_ext  = SW'(e_la_ff);
   assign load_ok = (la_ext < STORE_END);
   assign wr_en   = adv && e_v_ff && e_load_ff && load_ok;

   // Each tap reads its own copy of the source store; loads write all copies.
   for (genvar g = 0; g < 4; g++) begin : g_store
      bcs_ram #(
         .WIDTH(8),
         .DEPTH(SOURCE_BYTES)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr_en),
         .wr_addr(la_ext[AW-1:0]),
         .wr_data(e_lv_ff),
         .rd_en  (adv),
         .rd_addr(tap_addr[g][AW-1:0]),
         .rd_data(rd_data[g])
      );
   end

   assign sum = SUM_W'(m_p_ff[0]) + SUM_W'(m_p_ff[1]) + SUM_W'(m_p_ff[2]) + SUM_W'(m_p_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         e_c_ff <= 2'd0;
         r_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (take_e) begin
            e_v_ff <= in_valid;
            e_c_ff <= 2'd0;
         end else if (adv && e_v_ff) begin
            e_c_ff <= e_c_ff + 2'd1;
         end
         if (adv) begin
            r_v_ff <= issue;
            m_v_ff <= r_v_ff;
            o_v_ff <= m_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_e) begin
         e_load_ff    <= in_load;
         e_la_ff      <= in_load_address;
         e_lv_ff      <= in_load_value;
         e_addr_ff[0] <= i1;
         e_addr_ff[1] <= i3;
         e_addr_ff[2] <= i2;
         e_addr_ff[3] <= i4;
         e_w_ff[0]    <= in_wa;
         e_w_ff[1]    <= in_wb;
         e_w_ff[2]    <= in_wc;
         e_w_ff[3]    <= in_wd;
         e_row_ff     <= in_row_addr;
         e_lastc_ff   <= 2'(cfg.channels - 3'd1);
      end
      if (adv) begin
         r_addr_ff <= e_row_ff + 22'(e_c_ff);
         r_c_ff    <= e_c_ff;
         r_err_ff  <= err_now;
         r_last_ff <= (e_c_ff == e_lastc_ff);
         m_addr_ff <= r_addr_ff;
         m_c_ff    <= r_c_ff;
         m_err_ff  <= r_err_ff;
         m_last_ff <= r_last_ff;
         o_addr_ff <= m_addr_ff;
         o_c_ff    <= m_c_ff;
         o_err_ff  <= m_err_ff;
         o_last_ff <= m_last_ff;
         o_val_ff  <= m_err_ff ? 8'd0 : sum[2*FB+7:2*FB];
         for (int k = 0; k < 4; k++) begin
            r_w_ff[k] <= e_w_ff[k];
            m_p_ff[k] <= rd_data[k] * r_w_ff[k];
         end
      end
   end

   assign rsp_valid         = o_v_ff;
   assign rsp_dest_address  = o_addr_ff;
   assign rsp_pixel_value   = o_val_ff;
   assign rsp_channel_index = o_c_ff;
   assign rsp_range_error   = o_err_ff;
   assign rsp_last          = o_last_ff;

endmodule

FILE: hdl/bilinear_crop_scale_core.sv
// Top level of the bilinear crop-and-scale block: registers and pipeline wiring.
//
// Requests arrive on the req_ valid/ready channel. A load request (opcode 0)
// writes one byte of the source image into the on-chip source store and gives
// no response. A compute request (opcode 1) names one destination pixel and
// the origin of its box; it gives one response per channel on the rsp_ channel,
// in channel order, with last set on the final channel. Registers must be
// written through the csr_ port while the block is idle; it does not enforce this.
//
// A request passes four mapping stages (box offset, step products, source
// position, weights), then a channel sequencer that issues one channel per
// cycle to four copies of the source store, one per bilinear tap, then a
// multiply stage and a sum stage; each response passes the mapping, sequencer,
// read, multiply and sum registers. While rsp_ready is high, throughput is one
// response per cycle, and a pixel holds the sequencer until its channels issue.
//
// Reset clears all valid bits and loads the register defaults; the source
// store is not cleared and must be loaded before it is sampled. When the
// receiver holds rsp_ready low, the back stages freeze and the mapping
// stages fill up before req_ready drops; nothing is lost or repeated.
module bilinear_crop_scale_core #(
   parameter int SOURCE_BYTES = 1048576,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [19:0] req_load_address,
   input  logic [7:0]  req_load_value,
   input  logic [9:0]  req_dest_col,
   input  logic [9:0]  req_dest_row,
   input  logic [9:0]  req_box_left,
   input  logic [9:0]  req_box_top,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [21:0] rsp_dest_address,
   output logic [7:0]  rsp_pixel_value,
   output logic [1:0]  rsp_channel_index,
   output logic        rsp_range_error,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [bcs_pkg::CSR_W-1:0] csr_write_data
);

   localparam int WW = 2 * FRACTION_BITS + 1;
   localparam int SW = bcs_pkg::SAMP_W;

   logic [2:0]  chan_count_ff;
   logic [10:0] img_width_ff, img_height_ff, dest_width_ff;
   logic [9:0]  crop_left_ff, crop_top_ff;
   logic [23:0] step_x_ff, step_y_ff;

   bcs_pkg::cfg_type cfg;
   logic [2:0] chan_eff;

   // Register file; the write data is cut to each register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= 3'd3;
         img_width_ff  <= 11'd640;
         img_height_ff <= 11'd480;
         crop_left_ff  <= 10'd0;
         crop_top_ff   <= 10'd0;
         step_x_ff     <= 24'd65536;
         step_y_ff     <= 24'd65536;
         dest_width_ff <= 11'd640;
      end else if (csr_write_enable) begin
         case (bcs_pkg::csr_index_type'(csr_index))
            bcs_pkg::CSR_CHANNEL_COUNT: chan_count_ff <= csr_write_data[2:0];
            bcs_pkg::CSR_SOURCE_WIDTH:  img_width_ff  <= csr_write_data[10:0];
            bcs_pkg::CSR_SOURCE_HEIGHT: img_height_ff <= csr_write_data[10:0];
            bcs_pkg::CSR_CROP_LEFT:     crop_left_ff  <= csr_write_data[9:0];
            bcs_pkg::CSR_CROP_TOP:      crop_top_ff   <= csr_write_data[9:0];
            bcs_pkg::CSR_STEP_X:        step_x_ff     <= csr_write_data[23:0];
            bcs_pkg::CSR_STEP_Y:        step_y_ff     <= csr_write_data[23:0];
            bcs_pkg::CSR_DEST_WIDTH:    dest_width_ff <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   // A channel count of zero acts as one; counts above the maximum saturate.
   always_comb begin
      if (chan_count_ff == 3'd0) begin
         chan_eff = 3'd1;
      end else if (chan_count_ff > 3'(MAX_CHANNELS)) begin
         chan_eff = 3'(MAX_CHANNELS);
      end else begin
         chan_eff = chan_count_ff;
      end
   end

   assign cfg.channels      = chan_eff;
   assign cfg.source_width  = img_width_ff;
   assign cfg.source_height = img_height_ff;
   assign cfg.crop_left     = crop_left_ff;
   assign cfg.crop_top      = crop_top_ff;
   assign cfg.step_x        = step_x_ff;
   assign cfg.step_y        = step_y_ff;
   assign cfg.dest_width    = dest_width_ff;

   logic          map_valid, map_ready, map_load, map_sxl, map_syl;
   logic [19:0]   map_la;
   logic [7:0]    map_lv;
   logic [SW-1:0] map_sx, map_syw;
   logic [WW-1:0] map_wa, map_wb, map_wc, map_wd;
   logic [21:0]   map_row;

   bcs_map #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_map (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_opcode       (req_opcode),
      .in_load_address (req_load_address),
      .in_load_value   (req_load_value),
      .in_dest_col     (req_dest_col),
      .in_dest_row     (req_dest_row),
      .in_box_left     (req_box_left),
      .in_box_top      (req_box_top),
      .out_valid       (map_valid),
      .out_ready       (map_ready),
      .out_load        (map_load),
      .out_load_address(map_la),
      .out_load_value  (map_lv),
      .out_sx          (map_sx),
      .out_syw         (map_syw),
      .out_sx_last     (map_sxl),
      .out_sy_last     (map_syl),
      .out_wa          (map_wa),
      .out_wb          (map_wb),
      .out_wc          (map_wc),
      .out_wd          (map_wd),
      .out_row_addr    (map_row)
   );

   bcs_lane #(
      .SOURCE_BYTES (SOURCE_BYTES),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_lane (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (map_valid),
      .in_ready         (map_ready),
      .in_load          (map_load),
      .in_load_address  (map_la),
      .in_load_value    (map_lv),
      .in_sx            (map_sx),
      .in_syw           (map_syw),
      .in_sx_last       (map_sxl),
      .in_sy_last       (map_syl),
      .in_wa            (map_wa),
      .in_wb            (map_wb),
      .in_wc            (map_wc),
      .in_wd            (map_wd),
      .in_row_addr      (map_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_address (rsp_dest_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_channel_index(rsp_channel_index),
      .rsp_range_error  (rsp_range_error),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: verif/bilinear_crop_scale_core_test.sv
// Self-checking testbench of the bilinear crop-and-scale core.
module bilinear_crop_scale_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES = 1048576;
   localparam int FRAC = 16;
   localparam int DRAIN_CYCLES = 16;

   // One request as the sender presents it.
   typedef struct {
      logic        opcode;
      logic [19:0] load_address;
      logic [7:0]  load_value;
      logic [9:0]  dest_col;
      logic [9:0]  dest_row;
      logic [9:0]  box_left;
      logic [9:0]  box_top;
   } pixel_request_type;

   // One channel result as the core should give it.
   typedef struct {
      logic [21:0] dest_address;
      logic [7:0]  pixel_value;
      logic [1:0]  channel_index;
      logic        range_error;
      logic        last;
   } channel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = bcs_pkg::OP_LOAD;
   logic [19:0] req_load_address = '0;
   logic [7:0]  req_load_value = '0;
   logic [9:0]  req_dest_col = '0;
   logic [9:0]  req_dest_row = '0;
   logic [9:0]  req_box_left = '0;
   logic [9:0]  req_box_top = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [21:0] rsp_dest_address;
   logic [7:0]  rsp_pixel_value;
   logic [1:0]  rsp_channel_index;
   logic        rsp_range_error;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [bcs_pkg::CSR_W-1:0] csr_write_data = '0;

   bilinear_crop_scale_core i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Shadow copy of the registers, at their hardware widths.
   logic [2:0]  chan_cfg = 3'd3;
   logic [10:0] img_width = 11'd640;
   logic [10:0] img_height = 11'd480;
   logic [9:0]  crop_x = '0;
   logic [9:0]  crop_y = '0;
   logic [23:0] ratio_x = 24'd65536;
   logic [23:0] ratio_y = 24'd65536;
   logic [10:0] out_width = 11'd640;

   // Source bytes the core holds; an entry exists once it has been loaded.
   logic [7:0] source_bytes [int];

   channel_result_type pending_pixels [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int mismatches = 0;
   int loads_sent = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   int errors_seen = 0;

   function automatic int eff_channels();
      if (chan_cfg == 0) return 1;
      if (chan_cfg > 4) return 4;
      return int'(chan_cfg);
   endfunction

   function automatic bit in_store(longint a);
      return a >= 0 && a < STORE_BYTES;
   endfunction

   // Base addresses of the four taps: upper left, right, below, below right.
   function automatic void map_taps(input pixel_request_type r, output longint tap[4],
                                    output longint unsigned fx, output longint unsigned fy);
      logic [9:0] ox, oy;
      longint unsigned px, py;
      longint sx, sy, w, h, chs;
      ox = r.dest_col - r.box_left;
      oy = r.dest_row - r.box_top;
      px = longint'(ox) * longint'(ratio_x);
      py = longint'(oy) * longint'(ratio_y);
      fx = px & ((64'd1 << FRAC) - 1);
      fy = py & ((64'd1 << FRAC) - 1);
      sx = longint'(px >> FRAC) + longint'(crop_x);
      sy = longint'(py >> FRAC) + longint'(crop_y);
      w = longint'(img_width);
      h = longint'(img_height);
      chs = eff_channels();
      tap[0] = (sy * w + sx) * chs;
      // The bottom row and the right column borrow their neighbor taps
      // from the row above and the column to the left.
      tap[2] = (sy == h - 1) ? tap[0] - w * chs : tap[0] + w * chs;
      tap[1] = (sx == w - 1) ? tap[0] - chs : tap[0] + chs;
      tap[3] = (sx == w - 1) ? tap[2] - chs : tap[2] + chs;
   endfunction

   function automatic void predict_pixel(pixel_request_type r);
      longint tap[4];
      longint unsigned fx, fy, one, sum, row_addr;
      longint unsigned a, b, c, d;
      int chs;
      channel_result_type e;
      map_taps(r, tap, fx, fy);
      one = 64'd1 << FRAC;
      chs = eff_channels();
      row_addr = (longint'(r.dest_row) * longint'(out_width) + longint'(r.dest_col)) * chs;
      for (int ch = 0; ch < chs; ch++) begin
         e.dest_address = 22'(row_addr + ch);
         e.channel_index = 2'(ch);
         e.last = (ch == chs - 1);
         e.range_error = 1'b1;
         e.pixel_value = '0;
         if (in_store(tap[0] + ch) && in_store(tap[1] + ch) &&
             in_store(tap[2] + ch) && in_store(tap[3] + ch)) begin
            a = source_bytes[int'(tap[0] + ch)];
            b = source_bytes[int'(tap[1] + ch)];
            c = source_bytes[int'(tap[2] + ch)];
            d = source_bytes[int'(tap[3] + ch)];
            sum = a * (one - fx) * (one - fy) + b * fx * (one - fy)
                + c * (one - fx) * fy + d * fx * fy;
            e.pixel_value = 8'(sum >> (2 * FRAC));
            e.range_error = 1'b0;
         end
         pending_pixels.push_back(e);
      end
   endfunction

   // Presents one request, holding it until the core takes it. Called at a
   // rising edge; returns at the edge where the request was accepted.
   task automatic send_request(pixel_request_type r);
      int gap;
      bit took;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_load_address <= r.load_address;
      req_load_value <= r.load_value;
      req_dest_col <= r.dest_col;
      req_dest_row <= r.dest_row;
      req_box_left <= r.box_left;
      req_box_top <= r.box_top;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      if (r.opcode == bcs_pkg::OP_LOAD) begin
         source_bytes[int'(r.load_address)] = r.load_value;
         loads_sent++;
      end else begin
         predict_pixel(r);
         pixels_sent++;
      end
   endtask

   task automatic send_load(int addr, logic [7:0] value);
      pixel_request_type r;
      r = '{bcs_pkg::OP_LOAD, 20'(addr), value, 10'($urandom), 10'($urandom),
            10'($urandom), 10'($urandom)};
      send_request(r);
   endtask

   // Sends one compute request, first loading any tap byte it would read
   // that has not been written yet.
   task automatic send_pixel(int col, int row, int bl, int bt);
      pixel_request_type r;
      longint tap[4];
      longint unsigned fx, fy;
      longint a;
      r = '{bcs_pkg::OP_COMPUTE, 20'($urandom), 8'($urandom), 10'(col), 10'(row), 10'(bl),
            10'(bt)};
      map_taps(r, tap, fx, fy);
      for (int ch = 0; ch < eff_channels(); ch++) begin
         for (int t = 0; t < 4; t++) begin
            a = tap[t] + ch;
            if (in_store(a) && !source_bytes.exists(int'(a)))
               send_load(int'(a), 8'($urandom));
         end
      end
      send_request(r);
   endtask

   // Lets every result arrive and any trailing load finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers, in index order, once the core is idle.
   task automatic write_config(int chans, int w, int h, int cl, int ct,
                               int stx, int sty, int dw);
      logic [23:0] vals [8];
      bcs_pkg::csr_index_type idx;
      drain();
      vals = '{24'(chans), 24'(w), 24'(h), 24'(cl), 24'(ct), 24'(stx), 24'(sty), 24'(dw)};
      for (int k = 0; k < 8; k++) begin
         idx = bcs_pkg::csr_index_type'(k);
         csr_write_enable <= 1'b1;
         csr_index <= idx;
         csr_write_data <= vals[k];
         case (idx)
            bcs_pkg::CSR_CHANNEL_COUNT: chan_cfg = vals[k][2:0];
            bcs_pkg::CSR_SOURCE_WIDTH:  img_width = vals[k][10:0];
            bcs_pkg::CSR_SOURCE_HEIGHT: img_height = vals[k][10:0];
            bcs_pkg::CSR_CROP_LEFT:     crop_x = vals[k][9:0];
            bcs_pkg::CSR_CROP_TOP:      crop_y = vals[k][9:0];
            bcs_pkg::CSR_STEP_X:        ratio_x = vals[k];
            bcs_pkg::CSR_STEP_Y:        ratio_y = vals[k];
            bcs_pkg::CSR_DEST_WIDTH:    out_width = vals[k][10:0];
            default: ;
         endcase
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Directed cases: default registers, store edges, border taps, box wrap,
   // clamped channel counts and out-of-store samples.
   task automatic test_directed();
      // Reset configuration, including the lowest and highest store bytes.
      send_load(0, 8'h00);
      send_load(STORE_BYTES - 1, 8'hFF);
      send_pixel(0, 0, 0, 0);
      send_pixel(5, 7, 4, 6);
      // Small image with a fractional horizontal step.
      write_config(4, 4, 3, 0, 0, 98304, 65536, 1024);
      send_pixel(1, 1, 0, 0);
      send_pixel(2, 2, 0, 0);       // right column and bottom row together
      send_pixel(1, 1023, 1023, 1021); // box origin past the pixel wraps
      send_pixel(1023, 1023, 1022, 1022);
      // A channel count of zero acts as one, above four acts as four.
      write_config(0, 5, 4, 1, 1, 32768, 49152, 0);
      send_pixel(2, 1, 0, 0);
      send_pixel(3, 2, 0, 0);
      write_config(7, 5, 4, 0, 0, 65536, 32768, 2047);
      send_pixel(1023, 1023, 1020, 1020);
      send_pixel(4, 3, 0, 0);
      // Largest image: the far corner of the crop lies outside the store.
      write_config(4, 1024, 1024, 1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 2047);
      send_pixel(1023, 1023, 0, 0);
      send_pixel(0, 0, 0, 0);
      write_config(4, 1024, 1024, 0, 0, 0, 0, 1024);
      send_pixel(1023, 512, 0, 0);
      // A one-row image sends the lower taps to negative addresses.
      write_config(1, 2, 1, 0, 0, 0, 0, 2);
      send_pixel(0, 0, 0, 0);
      send_pixel(1, 1, 0, 0);
   endtask

   // A random small image, loaded whole, then mostly well-formed pixels of
   // its boxes with some noise requests and stray loads mixed in.
   task automatic test_random_image(int count);
      int w, h, bytes, ox, oy, bl, bt, pick;
      w = $urandom_range(2, 5);
      h = $urandom_range(2, 5);
      write_config($urandom_range(0, 7), w, h, $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 3 * 65536), $urandom_range(0, 3 * 65536),
                   $urandom_range(0, 2047));
      bytes = (w * h + w + 1) * eff_channels();
      for (int a = 0; a < bytes; a++) send_load(a, 8'($urandom));
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         bl = $urandom_range(0, 1023);
         bt = $urandom_range(0, 1023);
         if (pick < 84) begin
            ox = $urandom_range(0, w - 1);
            oy = $urandom_range(0, h - 1);
            send_pixel((bl + ox) % 1024, (bt + oy) % 1024, bl, bt);
         end else if (pick < 92) begin
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), bl, bt);
         end else begin
            send_load($urandom_range(0, bytes - 1), 8'($urandom));
            send_load($urandom_range(0, STORE_BYTES - 1), 8'($urandom));
         end
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming, so
   // the pipeline fills and req_ready drops. Afterward the sender waits for
   // every response before going on.
   task automatic test_backpressure();
      hold_cycles = 300;
      for (int n = 0; n < 20; n++) send_pixel($urandom_range(0, 3), $urandom_range(0, 3), 0, 0);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      send_pixel(1, 1, 0, 0);
   endtask

   // Receiver: a hold-off count overrides the random stalls.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Responses are sampled on the falling edge, where every signal is
   // settled; the handshake itself completes at the following rising edge.
   always @(negedge clock) begin
      channel_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_range_error) errors_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response addr=%0d value=%0d", rsp_dest_address,
                        rsp_pixel_value);
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_dest_address !== e.dest_address || rsp_pixel_value !== e.pixel_value ||
                rsp_channel_index !== e.channel_index ||
                rsp_range_error !== e.range_error || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("ERROR: expected addr=%0d value=%0d chan=%0d err=%0d last=%0d,",
                         e.dest_address, e.pixel_value, e.channel_index, e.range_error,
                         e.last);
                  $display(" got addr=%0d value=%0d chan=%0d err=%0d last=%0d",
                           rsp_dest_address, rsp_pixel_value, rsp_channel_index,
                           rsp_range_error, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 31;
      recv_idle_pct = 55;
      test_directed();
      test_random_image(12);
      test_backpressure();
      send_idle_pct = 55;
      recv_idle_pct = 31;
      test_random_image(12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_image(12);
      drain();
      if (pending_pixels.size() != 0) mismatches++;
      $display("Covered %0d compute and %0d load requests, %0d responses (%0d out of store).",
               pixels_sent, loads_sent, results_seen, errors_seen);
      $display("Register sets ranged from one-row images to the full 1024x1024 store.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("Timeout with %0d responses outstanding", pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
